// ===== sv/mtrc_pkg.sv =====
package mtrc_pkg;

    // Parse phases
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_FUNC   = 3'd2,
        PH_EXC    = 3'd3,
        PH_REGS   = 3'd4,
        PH_BITS   = 3'd5,
        PH_ECHO   = 3'd6
    } phase_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_WORD  = 2'd0,
        KIND_BIT   = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_ERR   = 2'd3
    } kind_t;

    // Status codes
    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_TXN      = 4'd1;
    localparam logic [3:0] ST_PROTO    = 4'd2;
    localparam logic [3:0] ST_UNIT     = 4'd3;
    localparam logic [3:0] ST_LENGTH   = 4'd4;
    localparam logic [3:0] ST_BARE_EXC = 4'd5;
    localparam logic [3:0] ST_EXC      = 4'd6;
    localparam logic [3:0] ST_FUNC     = 4'd7;
    localparam logic [3:0] ST_SIZE     = 4'd8;
    localparam logic [3:0] ST_ECHO     = 4'd9;
    localparam logic [3:0] ST_UNSUP    = 4'd10;

    // Function codes
    localparam logic [7:0] FC_READ_COILS    = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS   = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_RG = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_WRITE_REG     = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
    localparam logic [7:0] EXC_FLAG         = 8'h80;

    localparam logic [15:0] MAX_MBAP_LENGTH = 16'd254;
    localparam int          MAX_BIT_COUNT_DEFAULT = 2000;

    // Register indexes
    localparam logic [2:0] REG_TXN      = 3'd0;
    localparam logic [2:0] REG_UNIT     = 3'd1;
    localparam logic [2:0] REG_FUNC     = 3'd2;
    localparam logic [2:0] REG_COUNT    = 3'd3;
    localparam logic [2:0] REG_ECHO_ADR = 3'd4;
    localparam logic [2:0] REG_ECHO_VAL = 3'd5;

endpackage

// ===== sv/modbus_tcp_response_checker_core.sv =====
// Channel | Dir | tdata                                  | tuser       | tlast
// s_      | in  | [7:0] rx_byte                          | frame_start | -
// m_      | out | [15:0] value, [19:16] status,          | kind        | last
//         |     | [27:20] exception_code, [28] drop_link |             |
// One byte is parsed per cycle in a single pass while the burst buffer is
// empty or its final beat is taken; results are loaded into the buffer and
// drained one beat per cycle while m_tready is high. A data byte of a bit
// response yields up to eight beats; all other bytes yield at most one.
// Reset (aresetn low, synchronous) puts the parser idle and the buffer empty.
module modbus_tcp_response_checker_core #(
    parameter int MAX_BIT_COUNT = mtrc_pkg::MAX_BIT_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] value, [19:16] status,
                                   // [27:20] exception_code, [28] drop_link
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [15:0] txn_id_reg;
    logic [7:0]  unit_id_reg;
    logic [7:0]  func_reg;
    logic [10:0] count_reg;
    logic [15:0] echo_adr_reg;
    logic [15:0] echo_val_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txn_id_reg   <= 16'd1;
            unit_id_reg  <= 8'd1;
            func_reg     <= 8'd3;
            count_reg    <= 11'd1;
            echo_adr_reg <= 16'd0;
            echo_val_reg <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_idx)
                mtrc_pkg::REG_TXN:      txn_id_reg   <= pwdata[15:0];
                mtrc_pkg::REG_UNIT:     unit_id_reg  <= pwdata[7:0];
                mtrc_pkg::REG_FUNC:     func_reg     <= pwdata[7:0];
                mtrc_pkg::REG_COUNT:    count_reg    <= pwdata[10:0];
                mtrc_pkg::REG_ECHO_ADR: echo_adr_reg <= pwdata[15:0];
                mtrc_pkg::REG_ECHO_VAL: echo_val_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (cfg_idx)
            mtrc_pkg::REG_TXN:      prdata = {16'd0, txn_id_reg};
            mtrc_pkg::REG_UNIT:     prdata = {24'd0, unit_id_reg};
            mtrc_pkg::REG_FUNC:     prdata = {24'd0, func_reg};
            mtrc_pkg::REG_COUNT:    prdata = {21'd0, count_reg};
            mtrc_pkg::REG_ECHO_ADR: prdata = {16'd0, echo_adr_reg};
            mtrc_pkg::REG_ECHO_VAL: prdata = {16'd0, echo_val_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // Parser state
    mtrc_pkg::phase_t phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [47:0] hdr_reg, hdr_next;
    logic [7:0]  blen_reg, blen_next;
    logic [7:0]  hold_reg, hold_next;
    logic [31:0] echo_reg, echo_next;
    logic [10:0] emit_reg, emit_next;

    // Result of this byte
    logic [3:0]  res_n;
    mtrc_pkg::kind_t res_kind;
    logic [15:0] res_word;
    logic [3:0]  res_status;
    logic [7:0]  res_exc;
    logic        res_drop;
    logic        res_last;

    // Burst buffer
    logic [3:0]  ob_rem_reg;
    logic [2:0]  ob_idx_reg;
    mtrc_pkg::kind_t ob_kind_reg;
    logic [15:0] ob_word_reg;
    logic [3:0]  ob_status_reg;
    logic [7:0]  ob_exc_reg;
    logic        ob_drop_reg;
    logic        ob_last_reg;
    logic [7:0]  ob_bits;

    logic        s_accept;
    logic        m_accept;
    logic [7:0]  b;
    logic [8:0]  body_pos;
    logic [8:0]  bit_bytes;
    logic [11:0] reg_body;
    logic [15:0] hdr_len;
    logic [10:0] bits_left;
    logic [3:0]  burst_n;

    assign m_tvalid = (ob_rem_reg != 4'd0);
    assign m_accept = m_tvalid & m_tready;
    assign s_tready = (ob_rem_reg == 4'd0) | (m_tready & (ob_rem_reg == 4'd1));
    assign s_accept = s_tvalid & s_tready;
    assign b        = s_tdata;

    // Header check and bit bursts only happen without a frame start,
    // so the stored state is what they see
    assign bit_bytes = 9'(({1'b0, count_reg} + 12'd7) >> 3);
    assign reg_body  = 12'd2 + {count_reg, 1'b0};
    assign hdr_len   = hdr_reg[15:0];
    assign bits_left = count_reg - emit_reg;
    assign burst_n   = (bits_left > 11'd8) ? 4'd8 : bits_left[3:0];

    // One-pass parse of the incoming byte
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        blen_next  = blen_reg;
        hold_next  = hold_reg;
        echo_next  = echo_reg;
        emit_next  = emit_reg;
        res_n      = 4'd0;
        res_kind   = mtrc_pkg::KIND_ERR;
        res_word   = 16'd0;
        res_status = mtrc_pkg::ST_OK;
        res_exc    = 8'd0;
        res_drop   = 1'b0;
        res_last   = 1'b1;
        body_pos   = 9'd0;

        if (s_tuser) begin
            pos_next   = 9'd0;
            hdr_next   = 48'd0;
            blen_next  = 8'd0;
            hold_next  = 8'd0;
            echo_next  = 32'd0;
            emit_next  = 11'd0;
            phase_next = mtrc_pkg::PH_HEADER;
        end

        if (phase_next == mtrc_pkg::PH_HEADER) begin
            if (pos_next < 9'd6) begin
                hdr_next = {hdr_next[39:0], b};
                pos_next = pos_next + 9'd1;
            end else begin
                if (hdr_next[47:32] != txn_id_reg)
                    res_status = mtrc_pkg::ST_TXN;
                else if (hdr_next[31:16] != 16'd0)
                    res_status = mtrc_pkg::ST_PROTO;
                else if (b != unit_id_reg)
                    res_status = mtrc_pkg::ST_UNIT;
                else if (hdr_len < 16'd2 || hdr_len > mtrc_pkg::MAX_MBAP_LENGTH)
                    res_status = mtrc_pkg::ST_LENGTH;
                if (res_status != mtrc_pkg::ST_OK) begin
                    res_n      = 4'd1;
                    res_drop   = 1'b1;
                    phase_next = mtrc_pkg::PH_IDLE;
                end else begin
                    blen_next  = 8'(hdr_len - 16'd1);
                    pos_next   = 9'd7;
                    phase_next = mtrc_pkg::PH_FUNC;
                end
            end
        end else if (phase_next != mtrc_pkg::PH_IDLE) begin
            body_pos = pos_next - 9'd7;
            pos_next = pos_next + 9'd1;
            case (phase_next)
                mtrc_pkg::PH_FUNC: begin
                    res_n = 4'd1;
                    phase_next = mtrc_pkg::PH_IDLE;
                    if (b == (func_reg | mtrc_pkg::EXC_FLAG)) begin
                        if (blen_next < 8'd2) begin
                            res_status = mtrc_pkg::ST_BARE_EXC;
                        end else begin
                            res_n = 4'd0;
                            phase_next = mtrc_pkg::PH_EXC;
                        end
                    end else if (b != func_reg) begin
                        res_status = mtrc_pkg::ST_FUNC;
                    end else if (func_reg inside {mtrc_pkg::FC_READ_HOLDING,
                                                  mtrc_pkg::FC_READ_INPUT_RG}) begin
                        if (count_reg == 11'd0 || {4'd0, blen_next} != reg_body) begin
                            res_status = mtrc_pkg::ST_SIZE;
                        end else begin
                            res_n = 4'd0;
                            phase_next = mtrc_pkg::PH_REGS;
                        end
                    end else if (func_reg inside {mtrc_pkg::FC_READ_COILS,
                                                  mtrc_pkg::FC_READ_INPUTS}) begin
                        if (count_reg == 11'd0
                            || {1'b0, count_reg} > 12'(MAX_BIT_COUNT)
                            || {1'b0, blen_next} != bit_bytes + 9'd2) begin
                            res_status = mtrc_pkg::ST_SIZE;
                        end else begin
                            res_n = 4'd0;
                            phase_next = mtrc_pkg::PH_BITS;
                        end
                    end else if (func_reg inside {mtrc_pkg::FC_WRITE_COIL,
                                                  mtrc_pkg::FC_WRITE_REG,
                                                  mtrc_pkg::FC_WRITE_MULTI}) begin
                        if (blen_next != 8'd5) begin
                            res_status = mtrc_pkg::ST_SIZE;
                        end else begin
                            res_n = 4'd0;
                            phase_next = mtrc_pkg::PH_ECHO;
                        end
                    end else begin
                        res_status = mtrc_pkg::ST_UNSUP;
                    end
                end
                mtrc_pkg::PH_EXC: begin
                    res_n      = 4'd1;
                    res_status = mtrc_pkg::ST_EXC;
                    res_exc    = b;
                    phase_next = mtrc_pkg::PH_IDLE;
                end
                mtrc_pkg::PH_REGS: begin
                    if (body_pos >= 9'd2) begin
                        if (!body_pos[0]) begin
                            hold_next = b;
                        end else begin
                            emit_next = emit_next + 11'd1;
                            res_n     = 4'd1;
                            res_kind  = mtrc_pkg::KIND_WORD;
                            res_word  = {hold_next, b};
                            res_last  = (emit_next >= count_reg);
                            if (res_last)
                                phase_next = mtrc_pkg::PH_IDLE;
                        end
                    end
                end
                mtrc_pkg::PH_BITS: begin
                    if (body_pos == 9'd1) begin
                        if ({1'b0, b} != bit_bytes) begin
                            res_n      = 4'd1;
                            res_status = mtrc_pkg::ST_SIZE;
                            phase_next = mtrc_pkg::PH_IDLE;
                        end
                    end else begin
                        res_n     = burst_n;
                        res_kind  = mtrc_pkg::KIND_BIT;
                        res_word  = {8'd0, b};
                        res_last  = (bits_left <= 11'd8);
                        emit_next = emit_next + 11'(burst_n);
                        if (res_last)
                            phase_next = mtrc_pkg::PH_IDLE;
                    end
                end
                mtrc_pkg::PH_ECHO: begin
                    echo_next = {echo_next[23:0], b};
                    if (body_pos >= 9'd4) begin
                        res_n      = 4'd1;
                        phase_next = mtrc_pkg::PH_IDLE;
                        if (echo_next[31:16] != echo_adr_reg
                            || echo_next[15:0] != echo_val_reg)
                            res_status = mtrc_pkg::ST_ECHO;
                        else
                            res_kind = mtrc_pkg::KIND_WRITE;
                    end
                end
                default: phase_next = mtrc_pkg::PH_IDLE;
            endcase
        end
    end

    // State update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mtrc_pkg::PH_IDLE;
            pos_reg   <= 9'd0;
            hdr_reg   <= 48'd0;
            blen_reg  <= 8'd0;
            hold_reg  <= 8'd0;
            echo_reg  <= 32'd0;
            emit_reg  <= 11'd0;
        end else if (s_accept) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            blen_reg  <= blen_next;
            hold_reg  <= hold_next;
            echo_reg  <= echo_next;
            emit_reg  <= emit_next;
        end
    end

    // Burst buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ob_rem_reg <= 4'd0;
            ob_idx_reg <= 3'd0;
        end else if (s_accept && res_n != 4'd0) begin
            ob_rem_reg <= res_n;
            ob_idx_reg <= 3'd0;
        end else if (m_accept) begin
            ob_rem_reg <= ob_rem_reg - 4'd1;
            ob_idx_reg <= ob_idx_reg + 3'd1;
        end
    end

    // Burst payload
    always_ff @(posedge aclk) begin
        if (s_accept && res_n != 4'd0) begin
            ob_kind_reg   <= res_kind;
            ob_word_reg   <= res_word;
            ob_status_reg <= res_status;
            ob_exc_reg    <= res_exc;
            ob_drop_reg   <= res_drop;
            ob_last_reg   <= res_last;
        end
    end

    // Output beat; bits go out LSB first
    assign ob_bits = ob_word_reg[7:0] >> ob_idx_reg;

    always_comb begin
        m_tdata = {3'd0, ob_drop_reg, ob_exc_reg, ob_status_reg, ob_word_reg};
        if (ob_kind_reg == mtrc_pkg::KIND_BIT)
            m_tdata[15:0] = {15'd0, ob_bits[0]};
    end
    assign m_tuser = ob_kind_reg;
    assign m_tlast = ob_last_reg & (ob_rem_reg == 4'd1);

endmodule
